// File: sv/cmmq_pkg.sv
// ----------------------------------------------------------------------------
// cmmq_pkg
// Types and constants shared by the complex magnitude max queue.
// ----------------------------------------------------------------------------
package cmmq_pkg;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;

    localparam logic [2:0] ST_PUSHED  = 3'd0;
    localparam logic [2:0] ST_POPPED  = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic signed [15:0] real_part;
        logic signed [15:0] imag_part;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic signed [15:0] out_real;
        logic signed [15:0] out_imag;
        logic [6:0]  fill_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic push_wr;   // write entry at count
        logic scan_rst;  // start a search
        logic scan_step; // compare one entry
        logic fix_rd;    // read last entry
        logic fix_wr;    // move last into best slot
        logic clr;       // empty queue
        logic out_load;  // form result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic empty;
        logic full;
        logic scan_done;
    } t_sts;

    function automatic logic [31:0] mag_of(input logic [31:0] e);
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [15:0] a;
        logic [15:0] b;
        begin
            re = e[31:16];
            im = e[15:0];
            a = re[15] ? 16'(-re) : 16'(re);
            b = im[15] ? 16'(-im) : 16'(im);
            // products need the full 32 bits
            mag_of = 32'(a) * 32'(a) + 32'(b) * 32'(b);
        end
    endfunction

endpackage

// File: sv/complex_magnitude_max_queue.sv
// ----------------------------------------------------------------------------
// complex_magnitude_max_queue
// Max-priority queue of complex pairs ordered by squared magnitude.
//
//   channel | direction | handshake            | payload
//   in      | input     | i_in_valid/o_in_ready | t_in_item
//   out     | output    | o_out_valid/i_out_ready | t_out_item
//
// push and clear go straight to the output state; pop does a linear search
// through the entry memory plus a three-stage compare pipeline.
// reset empties the queue at once; the memory needs no clearing pass.
// one item is in work at a time; a stalled result holds the block in its
// output state until taken, while the previous result register drains.
// ----------------------------------------------------------------------------
module complex_magnitude_max_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cmmq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cmmq_pkg::t_out_item o_out_data
);
    import cmmq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cmmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cmmq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out_data)
    );
endmodule

// File: sv/cmmq_ctrl.sv
// ----------------------------------------------------------------------------
// cmmq_ctrl
// Request sequencer: push, clear, or linear max search followed by fix-up.
// ----------------------------------------------------------------------------
module cmmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  cmmq_pkg::t_sts  i_sts,
    output cmmq_pkg::t_cmd  o_cmd
);
    import cmmq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DEC  = 6'b000010,
        S_SCAN = 6'b000100,
        S_FRD  = 6'b001000,
        S_FWR  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_emit;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        w_emit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.req[1]) begin
                    o_cmd.clr = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.req == REQ_PUSH) begin
                    o_cmd.push_wr = !i_sts.full;
                    n_state = S_OUT;
                end else if (i_sts.empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_rst = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_FRD;
            end
            S_FRD: begin
                o_cmd.fix_rd = 1'b1;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_cmd.fix_wr = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to drain
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    w_emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = w_emit ? 1'b1 : (r_ovalid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !i_sts.scan_done) |=> (r_state == S_SCAN))
        else $error("scan left early");
    a_fix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD) |=> (r_state == S_FWR))
        else $error("fix-up out of order");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_ovalid)
        else $error("result lost");
endmodule

// File: sv/cmmq_dp.sv
// ----------------------------------------------------------------------------
// cmmq_dp
// Entry memory, element count, max search and result register.
// ----------------------------------------------------------------------------
module cmmq_dp #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmmq_pkg::t_in_item i_in,
    input  cmmq_pkg::t_cmd     i_cmd,
    output cmmq_pkg::t_sts     o_sts,
    output cmmq_pkg::t_out_item o_out
);
    import cmmq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rd;
    t_in_item      r_req;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_ptr;      // next address issued to memory
    logic          r_rd_vld;   // r_rd holds entry r_cmp_idx
    logic [AW-1:0] r_cmp_idx;
    logic [AW-1:0] r_best_idx;
    logic [31:0]   r_best;
    logic [31:0]   r_best_mag;
    logic [31:0]   r_cand_mag;
    logic [31:0]   r_cand;
    logic [AW-1:0] r_cand_idx;
    logic          r_cand_vld;
    logic          r_first;
    logic [2:0]    r_status;
    logic [AW-1:0] w_rd_addr;
    logic          w_above;
    logic          w_issue;

    assign o_sts.req       = r_req.req_type;
    assign o_sts.empty     = (r_cnt == '0);
    assign o_sts.full      = (r_cnt == CW'(CAPACITY));
    assign o_sts.scan_done = (r_ptr == r_cnt) && !r_rd_vld && !r_cand_vld;

    assign w_issue   = i_cmd.scan_step && (r_ptr != r_cnt);
    assign w_rd_addr = i_cmd.fix_rd ? AW'(r_cnt - 1'b1) : r_ptr[AW-1:0];

    // magnitude ties go to larger re, then larger im
    always_comb begin
        if (r_cand_mag != r_best_mag) w_above = r_cand_mag > r_best_mag;
        else if (r_cand[31:16] != r_best[31:16])
            w_above = $signed(r_cand[31:16]) > $signed(r_best[31:16]);
        else w_above = $signed(r_cand[15:0]) > $signed(r_best[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr)
            r_mem[r_cnt[AW-1:0]] <= {r_req.real_part, r_req.imag_part};
        else if (i_cmd.fix_wr)
            r_mem[r_best_idx] <= r_rd;
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_in;
        if (i_cmd.scan_rst) begin
            r_ptr <= '0;
            r_first <= 1'b1;
        end else if (w_issue) begin
            r_ptr <= r_ptr + 1'b1;
        end
        r_cmp_idx  <= r_ptr[AW-1:0];
        // stage 2: magnitude of read entry
        r_cand     <= r_rd;
        r_cand_idx <= r_cmp_idx;
        r_cand_mag <= mag_of(r_rd);
        // stage 3: compare against running best
        if (r_cand_vld && (r_first || w_above)) begin
            r_best     <= r_cand;
            r_best_mag <= r_cand_mag;
            r_best_idx <= r_cand_idx;
            r_first    <= 1'b0;
        end
        if (i_cmd.out_load) begin
            o_out.status     <= r_status;
            o_out.out_real   <= (r_status == ST_POPPED) ? r_best[31:16] : '0;
            o_out.out_imag   <= (r_status == ST_POPPED) ? r_best[15:0] : '0;
            o_out.fill_count <= 7'(r_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_cand_vld <= 1'b0;
            r_status   <= ST_CLEARED;
        end else begin
            r_rd_vld   <= w_issue;
            r_cand_vld <= r_rd_vld;
            if (i_cmd.clr) begin
                r_cnt <= '0;
            end else if (i_cmd.push_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.fix_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
            // status is settled by the request and the count at accept time
            if (i_cmd.load) begin
                if (i_in.req_type[1])
                    r_status <= ST_CLEARED;
                else if (i_in.req_type == REQ_PUSH)
                    r_status <= o_sts.full ? ST_FULL : ST_PUSHED;
                else
                    r_status <= o_sts.empty ? ST_EMPTY : ST_POPPED;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("count beyond capacity");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_wr |-> !o_sts.full)
        else $error("push into full store");
    a_pop_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fix_rd |-> !o_sts.empty)
        else $error("pop from empty store");
endmodule

// File: tb/sv/complex_magnitude_max_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_magnitude_max_queue_tb
// Drives push, pop and clear requests into the magnitude max queue, tracks
// the queue contents in a local model and checks every result field by
// field, under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module complex_magnitude_max_queue_tb;
    import cmmq_pkg::*;

    localparam int          QDEPTH     = 64;
    localparam logic [1:0]  REQ_CLEAR  = 2'd2;
    localparam logic [1:0]  REQ_CLR_HI = 2'd3;   // unused code, acts as clear
    localparam longint      CYCLE_LIMIT = 3000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_data;

    complex_magnitude_max_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // queue model
    logic [31:0] heap_mem [QDEPTH];
    int          heap_cnt;
    t_out_item   result_q [$];

    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_left;
    int     n_errors;
    int     n_items;
    int     n_results;
    int     n_pops;
    int     n_full;
    longint cycles;

    function automatic longint mag_sq(input logic [31:0] e);
        longint re;
        longint im;
        begin
            re = longint'($signed(e[31:16]));
            im = longint'($signed(e[15:0]));
            mag_sq = re * re + im * im;
        end
    endfunction

    function automatic bit outranks(input logic [31:0] a, input logic [31:0] b);
        begin
            if (mag_sq(a) != mag_sq(b))
                outranks = mag_sq(a) > mag_sq(b);
            else if (a[31:16] != b[31:16])
                outranks = $signed(a[31:16]) > $signed(b[31:16]);
            else
                outranks = $signed(a[15:0]) > $signed(b[15:0]);
        end
    endfunction

    function automatic t_out_item queue_response(input t_in_item it);
        t_out_item r;
        int best;
        begin
            r = '0;
            if (it.req_type[1]) begin
                heap_cnt = 0;
                r.status = ST_CLEARED;
            end else if (it.req_type == REQ_PUSH) begin
                if (heap_cnt >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    heap_mem[heap_cnt] = {it.real_part, it.imag_part};
                    heap_cnt++;
                    r.status = ST_PUSHED;
                end
            end else if (heap_cnt == 0) begin
                r.status = ST_EMPTY;
            end else begin
                best = 0;
                for (int i = 1; i < heap_cnt; i++)
                    if (outranks(heap_mem[i], heap_mem[best]))
                        best = i;
                r.out_real = heap_mem[best][31:16];
                r.out_imag = heap_mem[best][15:0];
                heap_cnt--;
                heap_mem[best] = heap_mem[heap_cnt];
                r.status = ST_POPPED;
            end
            r.fill_count = 7'(heap_cnt);
            queue_response = r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_results, what, got, want);
    endtask

    // one item per call; valid stays high into the next call unless idling
    task automatic send_item(input logic [1:0] req, input logic [15:0] re,
                             input logic [15:0] im);
        t_in_item it;
        begin
            it.req_type  = req;
            it.real_part = re;
            it.imag_part = im;
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
            in_valid <= 1'b1;
            in_data  <= it;
            do @(posedge i_clk); while (!o_in_ready);
            result_q.push_back(queue_response(it));
            n_items++;
        end
    endtask

    task automatic sender_rest();
        begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        begin
            sender_rest();
            while (result_q.size() != 0)
                @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_part();
        case ($urandom_range(5))
            0: pick_part = 16'h8000;
            1: pick_part = 16'h7fff;
            2: pick_part = 16'($signed($urandom_range(8)) - 4);
            3: pick_part = 16'($urandom_range(255));
            default: pick_part = 16'($urandom);
        endcase
    endfunction

    // long receiver hold, counted down here
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // receiver and result check
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_left > 0) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        if (i_rst_n && o_out_valid && out_ready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result, status", o_out_data.status, -1);
            end else begin
                t_out_item want;
                want = result_q.pop_front();
                if (o_out_data.status != want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.out_real != want.out_real)
                    report_mismatch("out_real", o_out_data.out_real, want.out_real);
                if (o_out_data.out_imag != want.out_imag)
                    report_mismatch("out_imag", o_out_data.out_imag, want.out_imag);
                if (o_out_data.fill_count != want.fill_count)
                    report_mismatch("fill_count", o_out_data.fill_count,
                                    want.fill_count);
                if (want.status == ST_POPPED) n_pops++;
                if (want.status == ST_FULL) n_full++;
            end
            n_results++;
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("complex_magnitude_max_queue_tb: FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        begin
            send_item(REQ_POP, 16'h0, 16'h0);             // pop on empty
            send_item(REQ_PUSH, 16'h8000, 16'h8000);
            send_item(REQ_PUSH, 16'h7fff, 16'h7fff);
            send_item(REQ_PUSH, 16'h8000, 16'h0000);
            send_item(REQ_PUSH, 16'h0000, 16'h8000);
            // equal magnitudes, broken by re then im
            send_item(REQ_PUSH, 16'd3, 16'd4);
            send_item(REQ_PUSH, 16'd4, 16'd3);
            send_item(REQ_PUSH, -16'sd4, 16'd3);
            send_item(REQ_PUSH, 16'd5, 16'd0);
            send_item(REQ_PUSH, -16'sd5, 16'd0);
            send_item(REQ_PUSH, 16'd0, -16'sd5);
            send_item(REQ_PUSH, 16'd0, 16'd5);
            send_item(REQ_PUSH, 16'd3, 16'd4);            // identical copy
            repeat (13) send_item(REQ_POP, 16'hffff, 16'hffff);
            send_item(REQ_PUSH, 16'd1, 16'd1);
            send_item(REQ_CLR_HI, 16'h1234, 16'h5678);
            send_item(REQ_CLEAR, 16'h0, 16'h0);
            send_item(REQ_POP, 16'h0, 16'h0);
            drain();
        end
    endtask

    task automatic test_full_queue();
        begin
            for (int i = 0; i <= QDEPTH + 1; i++)
                send_item(REQ_PUSH, pick_part(), pick_part());
            repeat (3) send_item(REQ_POP, 16'h0, 16'h0);
            send_item(REQ_CLEAR, 16'h0, 16'h0);
            drain();
        end
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        int   fill_goal;
        logic [1:0] req;
        begin
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            fill_goal = $urandom_range(QDEPTH + 4);
            for (int i = 0; i < count; i++) begin
                if ($urandom_range(19) == 0) begin
                    req = $urandom_range(1) ? REQ_CLEAR : REQ_CLR_HI;
                    fill_goal = $urandom_range(QDEPTH + 4);
                end else if (heap_cnt < fill_goal) begin
                    req = ($urandom_range(3) == 0) ? REQ_POP : REQ_PUSH;
                end else begin
                    req = ($urandom_range(3) == 0) ? REQ_PUSH : REQ_POP;
                    if (heap_cnt == 0) fill_goal = $urandom_range(QDEPTH + 4);
                end
                send_item(req, pick_part(), pick_part());
            end
            drain();
        end
    endtask

    task automatic test_backpressure();
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            @(posedge i_clk);
            hold_left <= 400;
            for (int i = 0; i < 40; i++)
                send_item(i % 4 == 3 ? REQ_POP : REQ_PUSH, pick_part(), pick_part());
            send_item(REQ_CLEAR, 16'h0, 16'h0);
            drain();
        end
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        n_errors  = 0;
        n_items   = 0;
        n_results = 0;
        n_pops    = 0;
        n_full    = 0;
        cycles    = 0;
        heap_cnt  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_queue();
        test_random(0, 0, 180);
        test_random(59, 0, 180);
        test_random(0, 59, 180);
        test_random(20, 20, 180);
        test_backpressure();

        repeat (200) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d pops, %0d full drops",
                 n_items, n_results, n_pops, n_full);
        $display("idle mixes: none, sender, receiver, both, long receiver hold");
        if (n_errors == 0 && result_q.size() == 0) begin
            $display("complex_magnitude_max_queue_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, result_q.size());
            $display("complex_magnitude_max_queue_tb: FAIL");
        end
        $finish;
    end

endmodule
